>>> sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked every clock edge outside reset
`define KFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked every clock edge, reset included
`define KFT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/kft_pkg.sv
`default_nettype none

package kft_pkg;

    typedef logic [31:0] t_hash;
    typedef logic [15:0] t_tag;
    typedef logic [7:0]  t_byte;
    typedef logic [7:0]  t_len;
    typedef logic [2:0]  t_status;
    typedef logic [2:0]  t_count;
    typedef logic [1:0]  t_phase;

    localparam t_hash FNV_BASIS = 32'd2166136261;
    localparam t_hash FNV_PRIME = 32'd16777619;
    localparam t_len  MAX_BODY  = 8'd31;
    localparam t_count MAX_SECRET = 3'd4;
    localparam t_count TAG_DIGITS = 3'd4;
    localparam t_hash SECRET_WORD_RESET = 32'd1296183862;
    localparam t_count SECRET_LEN_RESET = 3'd4;

    // operations
    localparam logic OP_SIGN   = 1'b0;
    localparam logic OP_VERIFY = 1'b1;

    // register indexes
    localparam logic CFG_SECRET_WORD = 1'b0;
    localparam logic CFG_SECRET_LEN  = 1'b1;

    // result codes
    localparam t_status STS_OK        = 3'd0;
    localparam t_status STS_NO_PREFIX = 3'd1;
    localparam t_status STS_NO_SEP    = 3'd2;
    localparam t_status STS_BAD_LEN   = 3'd3;
    localparam t_status STS_NO_DIGITS = 3'd4;
    localparam t_status STS_MISMATCH  = 3'd5;

    // tail parser phases
    localparam t_phase TP_IDLE   = 2'd0;
    localparam t_phase TP_WANT_C = 2'd1;
    localparam t_phase TP_DIGITS = 2'd2;
    localparam t_phase TP_DONE   = 2'd3;

    localparam t_byte CH_BAR  = 8'h7C;
    localparam t_byte CH_C    = 8'h43;

    function automatic t_byte prefix_char(input logic [2:0] idx);
        t_byte c;
        case (idx)
            3'd0: c = 8'h49;   // I
            3'd1: c = 8'h4F;   // O
            3'd2: c = 8'h54;   // T
            3'd3: c = 8'h31;   // 1
            default: c = CH_BAR;
        endcase
        return c;
    endfunction

    // bit 4 set when the byte is a hex digit, low nibble its value
    function automatic logic [4:0] hex_digit(input t_byte b);
        logic [4:0] r;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    function automatic t_tag fold16(input t_hash h);
        return h[31:16] ^ h[15:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/kft_ifs.sv
`default_nettype none

interface kft_in_if;
    logic           valid;
    logic           ready;
    logic           operation;
    kft_pkg::t_byte data_byte;
    logic           last_byte;

    modport source (output valid, output operation, output data_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input operation, input data_byte, input last_byte,
                    output ready);
endinterface

interface kft_out_if;
    logic             valid;
    logic             ready;
    kft_pkg::t_status status;
    kft_pkg::t_tag    computed_tag;
    kft_pkg::t_tag    received_tag;
    kft_pkg::t_len    body_length;

    modport source (output valid, output status, output computed_tag, output received_tag,
                    output body_length, input ready);
    modport sink   (input valid, input status, input computed_tag, input received_tag,
                    input body_length, output ready);
endinterface

`default_nettype wire

>>> sv/kft_round.sv
`default_nettype none

// one fnv-1a round: xor in the byte, multiply by the prime
module kft_round (
    input  wire kft_pkg::t_hash i_hash,
    input  wire kft_pkg::t_byte i_byte,
    output kft_pkg::t_hash      o_hash
);
    import kft_pkg::*;

    t_hash w_mix;

    assign w_mix  = i_hash ^ {24'd0, i_byte};
    assign o_hash = w_mix * FNV_PRIME;

endmodule

`default_nettype wire

>>> sv/keyed_fnv_tag_sign_verify.sv
// keyed fnv-1a tag signer and verifier
//
// i_in carries one message word per handshake (operation, data_byte,
// last_byte); the operation is taken from the first word of a message.
// o_out carries one result word per message, produced only for the word
// marked last_byte. i_cfg_we / i_cfg_idx / i_cfg_data write the secret
// word (index 0) and the secret length (index 1); the user must do this only
// while the block is idle, as the block itself does not enforce it.
//
// each word is accepted in ST_IDLE and then passes through the shared fnv
// round unit in ST_BYTE; no new word is accepted until it is through. the
// last word then runs it once per secret byte (0 to 4 rounds) in ST_KEY,
// and the result goes from ST_DONE into the output register.
//
// the result sits in an output register; new words are accepted while it
// waits. a second result waits inside the block until the first is taken,
// and input is held off meanwhile.
// reset (synchronous, active low) restores the default secret and clears
// any partly received message.

`default_nettype none

`include "assert_macros.svh"

module keyed_fnv_tag_sign_verify (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    kft_in_if.sink               i_in,
    kft_out_if.source            o_out,
    input  wire                  i_cfg_we,
    input  wire [0:0]            i_cfg_idx,
    input  wire kft_pkg::t_hash  i_cfg_data
);
    import kft_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BYTE = 2'd1;
    localparam logic [1:0] ST_KEY  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state, n_state;

    // configuration
    t_hash  r_secret;
    t_count r_secret_len;

    // latched word
    t_byte  r_byte;
    logic   r_last;

    // message state
    t_hash  r_run_hash, n_run_hash;
    t_hash  r_saved_hash, n_saved_hash;
    t_len   r_saved_len, n_saved_len;
    t_len   r_count, n_count;
    logic   r_prefix_ok, n_prefix_ok;
    logic   r_sep_seen, n_sep_seen;
    t_phase r_phase, n_phase;
    t_count r_digits, n_digits;
    t_tag   r_tag, n_tag;
    logic   r_mode, n_mode;
    logic   r_ended, n_ended;
    logic   r_open, n_open;

    // keying accumulator and round counter
    t_hash  r_acc, n_acc;
    t_count r_kcnt, n_kcnt;

    // result register
    logic    r_out_valid;
    t_status r_status;
    t_tag    r_ctag, r_rtag;
    t_len    r_blen;

    logic    w_accept;
    logic    w_load;
    t_count  w_nsec;
    t_byte   w_secret_byte;
    t_hash   w_unit_h;
    t_byte   w_unit_b;
    t_hash   w_unit_out;
    logic [4:0] w_hex;
    t_tag    w_fold;
    t_status w_status;
    t_tag    w_ctag, w_rtag;
    t_len    w_blen;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // secret length 5..7 behaves as 4
    assign w_nsec = (r_secret_len > MAX_SECRET) ? MAX_SECRET : r_secret_len;

    // secret bytes go first byte from the top
    always_comb begin
        case (r_kcnt[1:0])
            2'd0:    w_secret_byte = r_secret[31:24];
            2'd1:    w_secret_byte = r_secret[23:16];
            2'd2:    w_secret_byte = r_secret[15:8];
            default: w_secret_byte = r_secret[7:0];
        endcase
    end

    // the one round unit: message bytes in ST_BYTE, secret bytes in ST_KEY
    assign w_unit_h = (r_state == ST_KEY) ? r_acc : r_run_hash;
    assign w_unit_b = (r_state == ST_KEY) ? w_secret_byte : r_byte;

    kft_round u_round (
        .i_hash (w_unit_h),
        .i_byte (w_unit_b),
        .o_hash (w_unit_out)
    );

    assign w_hex  = hex_digit(r_byte);
    assign w_fold = fold16(r_acc);

    // result fields from the finished message
    always_comb begin
        w_status = STS_OK;
        w_ctag   = '0;
        w_rtag   = '0;
        w_blen   = '0;
        if (r_mode == OP_SIGN) begin
            w_ctag = w_fold;
            w_blen = r_count;
        end else if (!r_prefix_ok || r_count < 8'd5) begin
            w_status = STS_NO_PREFIX;
        end else if (!r_sep_seen || r_phase == TP_IDLE || r_phase == TP_WANT_C) begin
            w_status = STS_NO_SEP;
        end else begin
            w_ctag = w_fold;
            w_rtag = r_tag;
            w_blen = r_saved_len;
            if (r_saved_len == 8'd0 || r_saved_len > MAX_BODY) begin
                w_status = STS_BAD_LEN;
            end else if (r_digits == 3'd0) begin
                w_status = STS_NO_DIGITS;
            end else if (w_fold != r_tag) begin
                w_status = STS_MISMATCH;
            end
        end
    end

    // result may enter the output register once it is free or being taken
    assign w_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state      = r_state;
        n_run_hash   = r_run_hash;
        n_saved_hash = r_saved_hash;
        n_saved_len  = r_saved_len;
        n_count      = r_count;
        n_prefix_ok  = r_prefix_ok;
        n_sep_seen   = r_sep_seen;
        n_phase      = r_phase;
        n_digits     = r_digits;
        n_tag        = r_tag;
        n_mode       = r_mode;
        n_ended      = r_ended;
        n_open       = r_open;
        n_acc        = r_acc;
        n_kcnt       = r_kcnt;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (!r_open) begin
                        n_mode = i_in.operation;
                        n_open = 1'b1;
                    end
                    n_state = ST_BYTE;
                end
            end
            ST_BYTE: begin
                if (!r_ended) begin
                    if (r_byte == 8'd0) begin
                        n_ended = 1'b1;
                    end else begin
                        if (r_mode == OP_VERIFY) begin
                            if (r_count < 8'd5 && r_byte != prefix_char(r_count[2:0])) begin
                                n_prefix_ok = 1'b0;
                            end
                            if (r_byte == CH_BAR) begin
                                n_saved_hash = r_run_hash;
                                n_saved_len  = r_count;
                                n_sep_seen   = 1'b1;
                                n_phase      = TP_WANT_C;
                                n_digits     = '0;
                                n_tag        = '0;
                            end else if (r_phase == TP_WANT_C) begin
                                n_phase = (r_byte == CH_C) ? TP_DIGITS : TP_IDLE;
                            end else if (r_phase == TP_DIGITS) begin
                                if (!w_hex[4]) begin
                                    n_phase = TP_DONE;
                                end else begin
                                    n_tag    = {r_tag[11:0], w_hex[3:0]};
                                    n_digits = r_digits + 3'd1;
                                    if (r_digits + 3'd1 >= TAG_DIGITS) begin
                                        n_phase = TP_DONE;
                                    end
                                end
                            end
                        end
                        n_run_hash = w_unit_out;
                        if (r_count != 8'hFF) begin
                            n_count = r_count + 8'd1;
                        end
                    end
                end
                if (r_last) begin
                    n_acc   = (r_mode == OP_VERIFY) ? n_saved_hash : n_run_hash;
                    n_kcnt  = '0;
                    n_state = ST_KEY;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_KEY: begin
                if (r_kcnt < w_nsec) begin
                    n_acc  = w_unit_out;
                    n_kcnt = r_kcnt + 3'd1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            default: begin
                if (w_load) begin
                    n_run_hash   = FNV_BASIS;
                    n_saved_hash = FNV_BASIS;
                    n_saved_len  = '0;
                    n_count      = '0;
                    n_prefix_ok  = 1'b1;
                    n_sep_seen   = 1'b0;
                    n_phase      = TP_IDLE;
                    n_digits     = '0;
                    n_tag        = '0;
                    n_mode       = OP_SIGN;
                    n_ended      = 1'b0;
                    n_open       = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_secret     <= SECRET_WORD_RESET;
            r_secret_len <= SECRET_LEN_RESET;
            r_run_hash   <= FNV_BASIS;
            r_saved_hash <= FNV_BASIS;
            r_saved_len  <= '0;
            r_count      <= '0;
            r_prefix_ok  <= 1'b1;
            r_sep_seen   <= 1'b0;
            r_phase      <= TP_IDLE;
            r_digits     <= '0;
            r_tag        <= '0;
            r_mode       <= OP_SIGN;
            r_ended      <= 1'b0;
            r_open       <= 1'b0;
            r_kcnt       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_run_hash   <= n_run_hash;
            r_saved_hash <= n_saved_hash;
            r_saved_len  <= n_saved_len;
            r_count      <= n_count;
            r_prefix_ok  <= n_prefix_ok;
            r_sep_seen   <= n_sep_seen;
            r_phase      <= n_phase;
            r_digits     <= n_digits;
            r_tag        <= n_tag;
            r_mode       <= n_mode;
            r_ended      <= n_ended;
            r_open       <= n_open;
            r_kcnt       <= n_kcnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SECRET_WORD: r_secret     <= i_cfg_data;
                    CFG_SECRET_LEN:  r_secret_len <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (w_accept) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.last_byte;
        end
        if (w_load) begin
            r_status <= w_status;
            r_ctag   <= w_ctag;
            r_rtag   <= w_rtag;
            r_blen   <= w_blen;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.computed_tag = r_ctag;
    assign o_out.received_tag = r_rtag;
    assign o_out.body_length  = r_blen;

    `KFT_ASSERT(a_one_word_per_pass, w_accept |=> !i_in.ready, "word accepted while busy")
    `KFT_ASSERT(a_key_rounds_bounded, (r_state == ST_KEY) |-> (r_kcnt <= w_nsec), "too many key rounds")
    `KFT_ASSERT(a_digits_bounded, r_digits <= TAG_DIGITS, "more than four tag digits")
    `KFT_ASSERT(a_result_after_last, (r_state == ST_DONE) |-> (r_last && r_open), "result without last word")

endmodule

`default_nettype wire
